// ----- rtl/core/olm_pkg.sv -----
// Package for the outstanding request latency model.
// Field widths, configuration indexes, reset values, default parameters and sequencer states.
package olm_pkg;

  localparam int unsigned MAX_OUTSTANDING_DEF = 16;
  localparam int unsigned TIME_BITS_DEF       = 48;

  localparam int unsigned TAG_W      = 8;
  localparam int unsigned PAYLOAD_W  = 13;
  localparam int unsigned OVERHEAD_W = 8;
  localparam int unsigned RATE_W     = 12;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned LIMIT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // bytes * 2048 + rate / 2 fits in 25 bits
  localparam int unsigned BYTES_W    = 14;
  localparam int unsigned DVD_W      = 25;
  localparam int unsigned DIV_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDPOINT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd6;

  localparam logic [PAYLOAD_W-1:0]  RST_PAYLOAD  = 13'd256;
  localparam logic [OVERHEAD_W-1:0] RST_OVERHEAD = 8'd24;
  localparam logic [RATE_W-1:0]     RST_RATE     = 12'd128;
  localparam logic [DELAY_W-1:0]    RST_FIXED    = 16'd1120;
  localparam logic [DELAY_W-1:0]    RST_ENDPOINT = 16'd1920;
  localparam logic [DELAY_W-1:0]    RST_GAP      = 16'd320;
  localparam logic [LIMIT_W-1:0]    RST_LIMIT    = 5'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RET_ISSUE,
    ST_RET_ADMIT,
    ST_LINK,
    ST_LINK_DONE,
    ST_FINISH
  } olm_state_e;

endpackage

// ----- rtl/core/olm_if.sv -----
// Handshake channels of the latency model: issued transactions and results.
// Depends on olm_pkg.
interface olm_tx_if import olm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] tx_tag;

  modport source (output valid, output tx_tag, input ready);
  modport sink   (input valid, input tx_tag, output ready);
endinterface

interface olm_res_if import olm_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [TAG_W-1:0]     result_tag;
  logic [TIME_BITS-1:0] issue_time;
  logic [TIME_BITS-1:0] admit_time;
  logic [TIME_BITS-1:0] finish_time;
  logic [TIME_BITS-1:0] wait_time;
  logic [TIME_BITS-1:0] wire_time;

  modport source (output valid, output result_tag, output issue_time, output admit_time,
                  output finish_time, output wait_time, output wire_time, input ready);
  modport sink   (input valid, input result_tag, input issue_time, input admit_time,
                  input finish_time, input wait_time, input wire_time, output ready);
endinterface

// ----- rtl/core/outstanding_request_latency_model.sv -----
// Outstanding request latency model, top level. Depends on olm_pkg, olm_if,
// olm_wire_div and olm_cmpl_mem.
// One item in, one result out. An accepted item takes the sequencer from
// ST_IDLE through ST_RET_ISSUE, ST_LINK, ST_LINK_DONE and ST_FINISH. It stays
// in ST_RET_ISSUE once more for each completion retired from the completion
// store, because the store head is compared once per cycle through its
// registered read port. When the store is at its limit, admission waits for
// the oldest completion in ST_RET_ADMIT, which likewise repeats per retired
// completion. ST_FINISH stalls while the output register still holds a result
// that has not been accepted. After reset and after a configuration write, a
// bit-serial divider recomputes the serialization time, and no item is taken
// meanwhile; a write during a run queues one more pass. A finished result
// sits in an output register while the next item is accepted and worked on.
module outstanding_request_latency_model import olm_pkg::*; #(
  parameter int unsigned MAX_OUTSTANDING = MAX_OUTSTANDING_DEF,
  parameter int unsigned TIME_BITS       = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  olm_tx_if.sink                tx_i,
  olm_res_if.source             res_o
);

  localparam int unsigned PTR_W = (MAX_OUTSTANDING > 1) ? $clog2(MAX_OUTSTANDING) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_OUTSTANDING + 1);
  localparam int unsigned LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // configuration
  logic [PAYLOAD_W-1:0]  payload_q;
  logic [OVERHEAD_W-1:0] overhead_q;
  logic [RATE_W-1:0]     rate_q;
  logic [DELAY_W-1:0]    fixed_q;
  logic [DELAY_W-1:0]    endpoint_q;
  logic [DELAY_W-1:0]    gap_q;
  logic [LIMIT_W-1:0]    limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q  <= RST_PAYLOAD;
      overhead_q <= RST_OVERHEAD;
      rate_q     <= RST_RATE;
      fixed_q    <= RST_FIXED;
      endpoint_q <= RST_ENDPOINT;
      gap_q      <= RST_GAP;
      limit_q    <= RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAYLOAD:  payload_q  <= cfg_wdata_i[PAYLOAD_W-1:0];
        CFG_OVERHEAD: overhead_q <= cfg_wdata_i[OVERHEAD_W-1:0];
        CFG_RATE:     rate_q     <= cfg_wdata_i[RATE_W-1:0];
        CFG_FIXED:    fixed_q    <= cfg_wdata_i[DELAY_W-1:0];
        CFG_ENDPOINT: endpoint_q <= cfg_wdata_i[DELAY_W-1:0];
        CFG_GAP:      gap_q      <= cfg_wdata_i[DELAY_W-1:0];
        CFG_LIMIT:    limit_q    <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // serialization time
  logic [TIME_BITS-1:0] wire_time;
  logic                 div_ready;

  olm_wire_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_we_i),
    .payload_i  (payload_q),
    .overhead_i (overhead_q),
    .rate_i     (rate_q),
    .wire_o     (wire_time),
    .ready_o    (div_ready)
  );

  // state
  olm_state_e           state_q, state_d;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [TIME_BITS-1:0] next_issue_q, next_issue_d;
  logic [TIME_BITS-1:0] link_free_q, link_free_d;
  logic [TIME_BITS-1:0] ep_free_q, ep_free_d;
  logic [TAG_W-1:0]     tag_q, tag_d;
  logic [TIME_BITS-1:0] issue_q, issue_d;
  logic [TIME_BITS-1:0] admit_q, admit_d;
  logic [TIME_BITS-1:0] lstart_q, lstart_d;
  logic [TIME_BITS-1:0] ldone_q, ldone_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [TAG_W-1:0]     out_tag_q;
  logic [TIME_BITS-1:0] out_issue_q, out_admit_q, out_finish_q, out_wait_q, out_wire_q;

  // memory port
  logic                 mem_we;
  logic [PTR_W-1:0]     mem_waddr;
  logic [TIME_BITS-1:0] mem_wdata;
  logic [TIME_BITS-1:0] head_time;

  olm_cmpl_mem #(
    .DEPTH (MAX_OUTSTANDING),
    .AW    (PTR_W),
    .DW    (TIME_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (head_d),
    .rdata_o (head_time)
  );

  // datapath helpers
  logic [TIME_BITS-1:0] retire_tgt;
  logic                 can_pop;
  logic [PTR_W-1:0]     head_inc;
  logic [LIM_W-1:0]     lim_ext, lim_eff;
  logic                 full;
  logic [PTR_W:0]       tail_sum;
  logic [TIME_BITS:0]   sum_fix, sum_link, sum_fin, sum_gap;
  logic [TIME_BITS-1:0] adm_fix, fin_base, finish;

  always_comb begin
    retire_tgt = (state_q == ST_RET_ADMIT) ? admit_q : issue_q;
    can_pop    = (cnt_q != '0) && (head_time <= retire_tgt);
    head_inc   = (head_q == PTR_W'(MAX_OUTSTANDING - 1)) ? '0 : head_q + 1'b1;

    lim_ext = LIM_W'(limit_q);
    if (lim_ext == '0) begin
      lim_eff = LIM_W'(1);
    end else if (lim_ext > LIM_W'(MAX_OUTSTANDING)) begin
      lim_eff = LIM_W'(MAX_OUTSTANDING);
    end else begin
      lim_eff = lim_ext;
    end
    full = LIM_W'(cnt_q) >= lim_eff;

    tail_sum  = {1'b0, head_q} + (PTR_W + 1)'(cnt_q);
    mem_waddr = (tail_sum >= (PTR_W + 1)'(MAX_OUTSTANDING))
              ? PTR_W'(tail_sum - (PTR_W + 1)'(MAX_OUTSTANDING))
              : PTR_W'(tail_sum);

    sum_fix  = {1'b0, admit_q} + (TIME_BITS + 1)'(fixed_q);
    adm_fix  = sum_fix[TIME_BITS] ? '1 : sum_fix[TIME_BITS-1:0];
    sum_link = {1'b0, lstart_q} + {1'b0, wire_time};
    fin_base = (ldone_q > ep_free_q) ? ldone_q : ep_free_q;
    sum_fin  = {1'b0, fin_base} + (TIME_BITS + 1)'(endpoint_q);
    finish   = sum_fin[TIME_BITS] ? '1 : sum_fin[TIME_BITS-1:0];
    sum_gap  = {1'b0, next_issue_q} + (TIME_BITS + 1)'(gap_q);
  end

  assign tx_i.ready = (state_q == ST_IDLE) && div_ready;
  assign mem_wdata  = finish;

  // sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    next_issue_d = next_issue_q;
    link_free_d  = link_free_q;
    ep_free_d    = ep_free_q;
    tag_d        = tag_q;
    issue_d      = issue_q;
    admit_d      = admit_q;
    lstart_d     = lstart_q;
    ldone_d      = ldone_q;
    mem_we       = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (tx_i.valid && tx_i.ready) begin
          tag_d   = tx_i.tx_tag;
          issue_d = next_issue_q;
          state_d = ST_RET_ISSUE;
        end
      end
      ST_RET_ISSUE: begin
        if (can_pop) begin
          head_d = head_inc;
          cnt_d  = cnt_q - 1'b1;
        end else if (full) begin
          admit_d = head_time;
          state_d = ST_RET_ADMIT;
        end else begin
          admit_d = issue_q;
          state_d = ST_LINK;
        end
      end
      ST_RET_ADMIT: begin
        if (can_pop) begin
          head_d = head_inc;
          cnt_d  = cnt_q - 1'b1;
        end else begin
          state_d = ST_LINK;
        end
      end
      ST_LINK: begin
        lstart_d = (adm_fix > link_free_q) ? adm_fix : link_free_q;
        state_d  = ST_LINK_DONE;
      end
      ST_LINK_DONE: begin
        ldone_d     = sum_link[TIME_BITS] ? '1 : sum_link[TIME_BITS-1:0];
        link_free_d = ldone_d;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          out_load     = 1'b1;
          mem_we       = 1'b1;
          cnt_d        = cnt_q + 1'b1;
          ep_free_d    = finish;
          next_issue_d = sum_gap[TIME_BITS] ? '1 : sum_gap[TIME_BITS-1:0];
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_load | (out_valid_q & ~res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      cnt_q        <= '0;
      next_issue_q <= '0;
      link_free_q  <= '0;
      ep_free_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      cnt_q        <= cnt_d;
      next_issue_q <= next_issue_d;
      link_free_q  <= link_free_d;
      ep_free_q    <= ep_free_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q    <= tag_d;
    issue_q  <= issue_d;
    admit_q  <= admit_d;
    lstart_q <= lstart_d;
    ldone_q  <= ldone_d;
    if (out_load) begin
      out_tag_q    <= tag_q;
      out_issue_q  <= issue_q;
      out_admit_q  <= admit_q;
      out_finish_q <= finish;
      out_wait_q   <= (admit_q >= issue_q) ? admit_q - issue_q : '0;
      out_wire_q   <= wire_time;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.result_tag  = out_tag_q;
  assign res_o.issue_time  = out_issue_q;
  assign res_o.admit_time  = out_admit_q;
  assign res_o.finish_time = out_finish_q;
  assign res_o.wait_time   = out_wait_q;
  assign res_o.wire_time   = out_wire_q;

endmodule

// ----- rtl/core/olm_wire_div.sv -----
// Serialization time unit: restoring divider, one quotient bit per cycle.
// Computes round((payload + overhead) * 2048 / rate). Depends on olm_pkg.
module olm_wire_div import olm_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [PAYLOAD_W-1:0]  payload_i,
  input  logic [OVERHEAD_W-1:0] overhead_i,
  input  logic [RATE_W-1:0]     rate_i,
  output logic [TIME_BITS-1:0]  wire_o,
  output logic                  ready_o
);

  logic                 need_q, need_d;
  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     shreg_q, shreg_d;
  logic [RATE_W-1:0]    rem_q, rem_d;

  logic [BYTES_W-1:0]   bytes;
  logic [RATE_W:0]      rem_sh;
  logic                 ge;

  always_comb begin
    bytes  = BYTES_W'(payload_i) + BYTES_W'(overhead_i);
    rem_sh = {rem_q, shreg_q[DVD_W-1]};
    ge     = rem_sh >= {1'b0, rate_i};

    need_d  = need_q | start_i;
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    shreg_d = shreg_q;
    rem_d   = rem_q;

    if (busy_q) begin
      shreg_d = {shreg_q[DVD_W-2:0], ge};
      rem_d   = ge ? RATE_W'(rem_sh - {1'b0, rate_i}) : RATE_W'(rem_sh);
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end else if (need_q) begin
      need_d  = start_i;
      busy_d  = 1'b1;
      cnt_d   = DIV_CNT_W'(DVD_W);
      shreg_d = DVD_W'({bytes, 11'b0}) + DVD_W'(rate_i[RATE_W-1:1]);
      rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= 1'b1;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      need_q <= need_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
  end

  assign ready_o = !need_q && !busy_q;
  assign wire_o  = (rate_i == '0) ? '1 : TIME_BITS'(shreg_q);

endmodule

// ----- rtl/core/olm_cmpl_mem.sv -----
// Completion time store: one write port, one registered read port.
// A write to the address being read is forwarded to the read data.
module olm_cmpl_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 48
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for outstanding_request_latency_model: drives transactions and
// config writes, predicts every result item and compares it field by field.
// Depends on olm_pkg, olm_tx_if, olm_res_if and the RTL top.
module tb_top;
  import olm_pkg::*;

  localparam int unsigned TBITS = TIME_BITS_DEF;
  localparam int unsigned DEPTH = MAX_OUTSTANDING_DEF;
  localparam logic [63:0] T_SAT = (64'd1 << TBITS) - 64'd1;

  typedef logic [6:0][CFG_DATA_W-1:0] reg_file_t;

  typedef struct packed {
    logic [TAG_W-1:0] res_tag;
    logic [TBITS-1:0] t_issue;
    logic [TBITS-1:0] t_admit;
    logic [TBITS-1:0] t_finish;
    logic [TBITS-1:0] t_queue;
    logic [TBITS-1:0] t_serial;
  } timing_t;

  typedef struct packed {
    logic [2:0]       preset;
    logic             known;
    logic [TAG_W-1:0] tag;
    timing_t          expv;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  olm_tx_if tx_if ();
  olm_res_if #(.TIME_BITS(TBITS)) res_if ();

  outstanding_request_latency_model #(
    .MAX_OUTSTANDING(DEPTH),
    .TIME_BITS      (TBITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .tx_i       (tx_if),
    .res_o      (res_if)
  );

  // timeline state of the link, mirrored on this side
  reg_file_t   cur_regs;
  logic [63:0] cmpl_times [DEPTH];
  int unsigned cmpl_cnt;
  int unsigned cmpl_head;
  logic [63:0] issue_next;
  logic [63:0] link_free;
  logic [63:0] ep_free;

  timing_t     pending_timings [$];
  int unsigned mismatches = 0;
  int          tx_idle_pct = 36;
  int          rx_idle_pct = 73;
  int          rx_hold_left = 0;
  reg_file_t   presets [6];
  row_t        script [$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL outstanding_request_latency_model");
    $finish;
  end

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] x;
    x = (a > T_SAT) ? T_SAT : a;
    if (b > T_SAT - x) return T_SAT;
    return x + b;
  endfunction

  function automatic logic [63:0] later(input logic [63:0] a, input logic [63:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic reg_file_t mk_regs(input int unsigned payload, input int unsigned overhead,
                                        input int unsigned rate, input int unsigned fixed,
                                        input int unsigned endpoint, input int unsigned gap,
                                        input int unsigned limit);
    reg_file_t r;
    r = '0;
    r[CFG_PAYLOAD]  = CFG_DATA_W'(payload);
    r[CFG_OVERHEAD] = CFG_DATA_W'(overhead);
    r[CFG_RATE]     = CFG_DATA_W'(rate);
    r[CFG_FIXED]    = CFG_DATA_W'(fixed);
    r[CFG_ENDPOINT] = CFG_DATA_W'(endpoint);
    r[CFG_GAP]      = CFG_DATA_W'(gap);
    r[CFG_LIMIT]    = CFG_DATA_W'(limit);
    return r;
  endfunction

  function automatic reg_file_t random_regs();
    int unsigned pick;
    int unsigned payload;
    int unsigned limit;
    pick = $urandom_range(99);
    if (pick < 5) payload = 0;
    else if (pick < 15) payload = $urandom_range(4097, 8191);
    else if (pick < 60) payload = $urandom_range(1, 256);
    else payload = $urandom_range(1, 4096);
    pick = $urandom_range(99);
    if (pick < 10) limit = 0;
    else if (pick < 20) limit = $urandom_range(17, 31);
    else limit = $urandom_range(1, 16);
    return mk_regs(payload, $urandom_range(0, 255),
                   $urandom_range(1, (1 << $urandom_range(1, 12)) - 1),
                   $urandom_range(0, (1 << $urandom_range(1, 16)) - 1),
                   $urandom_range(0, (1 << $urandom_range(1, 16)) - 1),
                   $urandom_range(0, (1 << $urandom_range(1, 16)) - 1), limit);
  endfunction

  task automatic retire_until(input logic [63:0] t);
    while (cmpl_cnt > 0 && cmpl_times[cmpl_head] <= t) begin
      cmpl_head = (cmpl_head + 1) % DEPTH;
      cmpl_cnt--;
    end
  endtask

  task automatic advance_link_timeline(input logic [TAG_W-1:0] tag, output timing_t r);
    int unsigned lim;
    logic [63:0] issue, admit, serial, bytes, rate, link_done, finish;
    lim = cur_regs[CFG_LIMIT][LIMIT_W-1:0];
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    issue = issue_next;
    retire_until(issue);
    admit = issue;
    if (cmpl_cnt >= lim) begin
      admit = cmpl_times[cmpl_head];
      retire_until(admit);
    end
    bytes = 64'(cur_regs[CFG_PAYLOAD][PAYLOAD_W-1:0]) +
            64'(cur_regs[CFG_OVERHEAD][OVERHEAD_W-1:0]);
    rate = 64'(cur_regs[CFG_RATE][RATE_W-1:0]);
    if (rate == 0) begin
      serial = T_SAT;
    end else begin
      // round to nearest, ties up
      serial = (bytes * 64'd2048 + rate / 2) / rate;
      if (serial > T_SAT) serial = T_SAT;
    end
    link_done = sat_sum(later(sat_sum(admit, 64'(cur_regs[CFG_FIXED])), link_free), serial);
    link_free = link_done;
    finish = sat_sum(later(link_done, ep_free), 64'(cur_regs[CFG_ENDPOINT]));
    ep_free = finish;
    cmpl_times[(cmpl_head + cmpl_cnt) % DEPTH] = finish;
    cmpl_cnt++;
    issue_next = sat_sum(issue_next, 64'(cur_regs[CFG_GAP]));
    r.res_tag  = tag;
    r.t_issue  = issue[TBITS-1:0];
    r.t_admit  = admit[TBITS-1:0];
    r.t_finish = finish[TBITS-1:0];
    r.t_queue  = (admit >= issue) ? TBITS'(admit - issue) : '0;
    r.t_serial = serial[TBITS-1:0];
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [TBITS-1:0] got,
                               input logic [TBITS-1:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task automatic check_result();
    timing_t e;
    if (pending_timings.size() == 0) begin
      flag_mismatch($sformatf("result tag %0d with no item outstanding", res_if.result_tag));
      return;
    end
    e = pending_timings.pop_front();
    compare_field("result_tag", TBITS'(res_if.result_tag), TBITS'(e.res_tag));
    compare_field("issue_time", res_if.issue_time, e.t_issue);
    compare_field("admit_time", res_if.admit_time, e.t_admit);
    compare_field("finish_time", res_if.finish_time, e.t_finish);
    compare_field("wait_time", res_if.wait_time, e.t_queue);
    compare_field("wire_time", res_if.wire_time, e.t_serial);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) check_result();
  end

  // result side: random back-pressure, or a long hold when requested
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        res_if.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [TAG_W-1:0] tag, output timing_t predicted);
    while ($urandom_range(99) < tx_idle_pct) begin
      tx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    tx_if.valid  <= 1'b1;
    tx_if.tx_tag <= tag;
    @(posedge clk_i);
    while (!tx_if.ready) @(posedge clk_i);
    advance_link_timeline(tag, predicted);
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    tx_if.valid <= 1'b0;
    while (pending_timings.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic load_settings(input reg_file_t regs);
    for (int i = CFG_PAYLOAD; i <= CFG_LIMIT; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(i);
      cfg_wdata_i <= regs[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_regs = regs;
  endtask

  task automatic add_row(input logic [2:0] preset, input logic [TAG_W-1:0] tag,
                         input logic known, input logic [TBITS-1:0] issue,
                         input logic [TBITS-1:0] admit, input logic [TBITS-1:0] finish,
                         input logic [TBITS-1:0] queued, input logic [TBITS-1:0] serial);
    row_t r;
    r.preset         = preset;
    r.known          = known;
    r.tag            = tag;
    r.expv.res_tag   = tag;
    r.expv.t_issue   = issue;
    r.expv.t_admit   = admit;
    r.expv.t_finish  = finish;
    r.expv.t_queue   = queued;
    r.expv.t_serial  = serial;
    script.insert(script.size(), r);
  endtask

  initial begin
    row_t        row;
    timing_t     predicted;
    logic [2:0]  active;
    int unsigned count;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    tx_if.valid  = 1'b0;
    tx_if.tx_tag = '0;

    presets[0] = mk_regs(RST_PAYLOAD, RST_OVERHEAD, RST_RATE, RST_FIXED, RST_ENDPOINT,
                         RST_GAP, RST_LIMIT);
    presets[1] = mk_regs(1, 0, 1, 0, 0, 0, 1);
    presets[2] = mk_regs(8191, 255, 4095, 65535, 65535, 0, 16);
    // limit dropped below the number of completions still held
    presets[3] = mk_regs(4096, 0, 4095, 100, 500, 65535, 2);
    // zero bytes on the wire, limit of zero
    presets[4] = mk_regs(0, 0, 4095, 0, 0, 65535, 0);
    // slowest link, limit above the store depth
    presets[5] = mk_regs(4096, 255, 1, 65535, 0, 65535, 31);

    add_row(3'd0, 8'h00, 1'b1, 48'd0,   48'd0,   48'd7520,  48'd0, 48'd4480);
    add_row(3'd0, 8'hFF, 1'b1, 48'd320, 48'd320, 48'd12000, 48'd0, 48'd4480);
    add_row(3'd0, 8'hA5, 1'b1, 48'd640, 48'd640, 48'd16480, 48'd0, 48'd4480);
    add_row(3'd1, 8'h5A, 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd1, 8'h0F, 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd1, 8'hF0, 1'b0, '0, '0, '0, '0, '0);
    for (int k = 0; k < 7; k++) add_row(3'd2, TAG_W'(8'h11 * k), 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd3, 8'h01, 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd3, 8'h80, 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd3, 8'h7F, 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd4, 8'hC3, 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd4, 8'h3C, 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd4, 8'h96, 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd5, 8'h69, 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd5, 8'hFE, 1'b0, '0, '0, '0, '0, '0);
    add_row(3'd5, 8'h01, 1'b0, '0, '0, '0, '0, '0);

    cur_regs   = presets[0];
    cmpl_cnt   = 0;
    cmpl_head  = 0;
    issue_next = '0;
    link_free  = '0;
    ep_free    = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    active = 3'd0;
    foreach (script[k]) begin
      row = script[k];
      if (row.preset != active) begin
        quiesce();
        load_settings(presets[row.preset]);
        active = row.preset;
      end
      send_item(row.tag, predicted);
      pending_timings.insert(pending_timings.size(), row.known ? row.expv : predicted);
    end

    for (int seg = 0; seg < 29; seg++) begin
      quiesce();
      if (seg == 10) begin
        tx_idle_pct = 73;
        rx_idle_pct = 36;
      end
      if (seg == 20) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      load_settings(random_regs());
      // long output stall while items keep coming
      if (seg == 4) rx_hold_left = 400;
      count = $urandom_range(40, 80);
      repeat (count) begin
        send_item(TAG_W'($urandom), predicted);
        pending_timings.insert(pending_timings.size(), predicted);
      end
    end

    // zero link rate saturates every later time, so it comes last
    quiesce();
    load_settings(mk_regs(256, 24, 0, 1120, 1920, 320, 8));
    repeat (3) begin
      send_item(TAG_W'($urandom), predicted);
      pending_timings.insert(pending_timings.size(), predicted);
    end
    quiesce();
    repeat (32) @(negedge clk_i);

    if (mismatches == 0 && pending_timings.size() == 0) begin
      $display("PASS outstanding_request_latency_model");
    end else begin
      $display("FAIL outstanding_request_latency_model");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/olm_pkg.sv
rtl/core/olm_if.sv
rtl/core/olm_wire_div.sv
rtl/core/olm_cmpl_mem.sv
rtl/core/outstanding_request_latency_model.sv
bench/tb_top.sv
